@@ hdl/ffa_pkg.sv @@
// Shared widths, codes and defaults for the first-fit unit allocator.
package ffa_pkg;

    localparam int ACT_W      = 2;
    localparam int PID_FLD_W  = 8;
    localparam int SIZE_W     = 11;
    localparam int ADDR_W     = 10;
    localparam int FRAG_W     = 11;
    localparam int LIMIT_W    = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic [FRAG_W-1:0]  FRAG_MAX    = 11'd2047;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MEASURE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;

    localparam int MEM_UNITS_DEF = 1024;
    localparam int PID_BITS_DEF  = 8;

endpackage

@@ hdl/ffa_if.sv @@
// Request and response channel interfaces of the allocator.
interface ffa_req_if;
    logic                         valid;
    logic                         ready;
    logic [ffa_pkg::ACT_W-1:0]     action;
    logic [ffa_pkg::PID_FLD_W-1:0] process_id;
    logic [ffa_pkg::SIZE_W-1:0]    request_size;

    modport source (output valid, output action, output process_id, output request_size,
                    input ready);
    modport sink   (input valid, input action, input process_id, input request_size,
                    output ready);
endinterface

interface ffa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [ffa_pkg::ADDR_W-1:0] start_address;
    logic [ffa_pkg::FRAG_W-1:0] fragment_units;

    modport source (output valid, output ok, output start_address, output fragment_units,
                    input ready);
    modport sink   (input valid, input ok, input start_address, input fragment_units,
                    output ready);
endinterface

@@ hdl/ffa_cell.sv @@
// One owner-map cell of the rotating ring.
module ffa_cell #(
    parameter int W = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_shift,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule

@@ hdl/first_fit_unit_allocator_core.sv @@
// Top level of the first-fit unit allocator: owner ring plus head processor.
//
// The owner map lives in a ring of MEM_UNITS cells, each holding a used bit
// and an owner id. A request rotates the ring through a single head
// processor that sees one unit per cycle, in address order, and writes it back.
// Free and measure take one pass of rotation; an allocate that finds a
// run takes two passes (one pass to locate the lowest fitting run, one pass
// to tag it), one that finds none takes one pass. A zero, oversized or
// unused request skips the ring. One request is in flight at a time; its
// response sits in an output register until transferred. Reset clears
// every cell to free.
module first_fit_unit_allocator_core #(
    parameter int MEM_UNITS = ffa_pkg::MEM_UNITS_DEF,
    parameter int PID_BITS  = ffa_pkg::PID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ffa_req_if.sink                     i_req,
    ffa_rsp_if.source                   o_rsp,
    input  logic                        i_cfg_we,
    input  logic [ffa_pkg::LIMIT_W-1:0] i_cfg_wdata
);
    localparam int CW   = PID_BITS + 1;               // cell width
    localparam int IDXW = $clog2(MEM_UNITS);
    localparam int RUNW = $clog2(MEM_UNITS + 1);
    localparam int EW   = (RUNW > ffa_pkg::LIMIT_W) ? RUNW + 1 : ffa_pkg::LIMIT_W + 1;
    localparam logic [IDXW-1:0] LAST = IDXW'(MEM_UNITS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    // ring
    logic [CW-1:0] w_q [MEM_UNITS];
    logic [CW-1:0] n_head;
    logic          w_shift;

    genvar g;
    generate
        for (g = 0; g < MEM_UNITS; g++) begin : g_cell
            ffa_cell #(.W(CW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     ((g == 0) ? n_head : w_q[(g == 0) ? 0 : g - 1]),
                .o_q     (w_q[g])
            );
        end
    endgenerate

    // control and working registers
    logic [1:0]                    r_state, n_state;
    logic [IDXW-1:0]               r_idx, n_idx;
    logic [ffa_pkg::ACT_W-1:0]     r_act, n_act;
    logic [PID_BITS-1:0]           r_pid, n_pid;
    logic [EW-1:0]                 r_size, n_size;
    logic [EW-1:0]                 r_run, n_run;
    logic [EW-1:0]                 r_total, n_total;
    logic                          r_found, n_found;
    logic [IDXW-1:0]               r_start, n_start;
    logic [EW-1:0]                 r_left, n_left;
    logic                          r_any, n_any;
    logic                          r_res_ok, n_res_ok;
    logic [EW-1:0]                 r_res_addr, n_res_addr;
    logic [EW-1:0]                 r_res_frag, n_res_frag;
    logic [ffa_pkg::LIMIT_W-1:0]   r_limit;
    logic                          r_ov;
    logic                          r_o_ok;
    logic [ffa_pkg::ADDR_W-1:0]    r_o_addr;
    logic [ffa_pkg::FRAG_W-1:0]    r_o_frag;

    logic [CW-1:0]                 w_head;
    logic                          w_used;
    logic                          w_last;
    logic [EW-1:0]                 w_lim;
    logic [EW-1:0]                 w_run_inc;
    logic [EW-1:0]                 w_add;
    logic [EW-1:0]                 w_req_size;
    logic [PID_BITS+ffa_pkg::PID_FLD_W-1:0] w_pid_ext;
    logic                          w_load;

    assign w_head     = w_q[MEM_UNITS-1];
    assign w_used     = w_head[PID_BITS];
    assign w_last     = (r_idx == LAST);
    assign w_lim      = EW'(r_limit);
    assign w_run_inc  = r_run + EW'(1);
    assign w_req_size = EW'(i_req.request_size);
    assign w_pid_ext  = {{PID_BITS{1'b0}}, i_req.process_id};
    assign w_shift    = (r_state == S_SCAN) || (r_state == S_FILL);
    assign w_load     = (r_state == S_RESP) && (!r_ov || o_rsp.ready);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_act      = r_act;
        n_pid      = r_pid;
        n_size     = r_size;
        n_run      = r_run;
        n_total    = r_total;
        n_found    = r_found;
        n_start    = r_start;
        n_left     = r_left;
        n_any      = r_any;
        n_res_ok   = r_res_ok;
        n_res_addr = r_res_addr;
        n_res_frag = r_res_frag;
        n_head     = w_head;
        w_add      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act      = i_req.action;
                    n_pid      = w_pid_ext[PID_BITS-1:0];
                    n_size     = w_req_size;
                    n_idx      = '0;
                    n_run      = '0;
                    n_total    = '0;
                    n_found    = 1'b0;
                    n_any      = 1'b0;
                    n_res_ok   = 1'b0;
                    n_res_addr = '0;
                    n_res_frag = '0;
                    n_state    = S_SCAN;
                    if (i_req.action == ffa_pkg::ACT_ALLOC) begin
                        // zero, over the limit or larger than memory: fail at once
                        if (w_req_size == '0 || w_req_size > w_lim ||
                            w_req_size > EW'(MEM_UNITS)) begin
                            n_state = S_RESP;
                        end
                    end else if (i_req.action != ffa_pkg::ACT_FREE &&
                                 i_req.action != ffa_pkg::ACT_MEASURE) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                n_idx = w_last ? '0 : r_idx + IDXW'(1);
                if (r_act == ffa_pkg::ACT_ALLOC) begin
                    if (w_used) begin
                        n_run = '0;
                    end else begin
                        n_run = w_run_inc;
                        if (!r_found && w_run_inc == r_size) begin
                            n_found = 1'b1;
                            n_start = IDXW'(EW'(r_idx) + EW'(1) - r_size);
                        end
                    end
                    if (w_last) begin
                        if (n_found) begin
                            n_left  = r_size;
                            n_state = S_FILL;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                end else if (r_act == ffa_pkg::ACT_FREE) begin
                    if (w_head == {1'b1, r_pid}) begin
                        n_head = '0;
                        n_any  = 1'b1;
                    end
                    if (w_last) begin
                        n_res_ok = n_any;
                        n_state  = S_RESP;
                    end
                end else begin
                    // measure: close a run on a used unit or at the end
                    if (w_used) begin
                        w_add = r_run;
                        n_run = '0;
                    end else begin
                        n_run = w_run_inc;
                        if (w_last) w_add = w_run_inc;
                    end
                    if (w_add != '0 && w_add < w_lim) n_total = r_total + w_add;
                    if (w_last) begin
                        n_res_ok   = 1'b1;
                        n_res_frag = n_total;
                        n_state    = S_RESP;
                    end
                end
            end
            S_FILL: begin
                n_idx = w_last ? '0 : r_idx + IDXW'(1);
                if (r_idx >= r_start && r_left != '0) begin
                    n_head = {1'b1, r_pid};
                    n_left = r_left - EW'(1);
                end
                if (w_last) begin
                    n_res_ok   = 1'b1;
                    n_res_addr = EW'(r_start);
                    n_state    = S_RESP;
                end
            end
            S_RESP: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_limit <= ffa_pkg::LIMIT_RESET;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_pid      <= n_pid;
        r_size     <= n_size;
        r_run      <= n_run;
        r_total    <= n_total;
        r_found    <= n_found;
        r_start    <= n_start;
        r_left     <= n_left;
        r_any      <= n_any;
        r_res_ok   <= n_res_ok;
        r_res_addr <= n_res_addr;
        r_res_frag <= n_res_frag;
        if (w_load) begin
            r_o_ok   <= r_res_ok;
            r_o_addr <= r_res_addr[ffa_pkg::ADDR_W-1:0];
            r_o_frag <= (r_res_frag > EW'(ffa_pkg::FRAG_MAX)) ? ffa_pkg::FRAG_MAX
                                                              : r_res_frag[ffa_pkg::FRAG_W-1:0];
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.ok             = r_o_ok;
    assign o_rsp.start_address  = r_o_addr;
    assign o_rsp.fragment_units = r_o_frag;
endmodule

@@ verif/ffa_scoreboard.sv @@
// Allocator scoreboard: tracks the owner map, predicts each response and checks it.
module ffa_scoreboard (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ffa_req_if                          i_req,
    ffa_rsp_if                          i_rsp,
    input  logic                        i_cfg_we,
    input  logic [ffa_pkg::LIMIT_W-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    localparam int UNITS = ffa_pkg::MEM_UNITS_DEF;
    localparam int PIDB  = ffa_pkg::PID_BITS_DEF;

    typedef struct packed {
        logic                       ok;
        logic [ffa_pkg::ADDR_W-1:0] start_address;
        logic [ffa_pkg::FRAG_W-1:0] fragment_units;
    } t_alloc_resp;

    logic [PIDB:0]               owner_tag [UNITS];
    logic [ffa_pkg::LIMIT_W-1:0] unit_limit;
    t_alloc_resp                 resp_fifo[$];

    function automatic int free_run_total();
        int total;
        int run;
        total = 0;
        run = 0;
        for (int i = 0; i < UNITS; i++) begin
            if (!owner_tag[i][PIDB]) begin
                run++;
            end else begin
                if (run != 0 && run < unit_limit) total += run;
                run = 0;
            end
        end
        if (run != 0 && run < unit_limit) total += run;
        return (total > ffa_pkg::FRAG_MAX) ? ffa_pkg::FRAG_MAX : total;
    endfunction

    function automatic t_alloc_resp predict_resp(logic [ffa_pkg::ACT_W-1:0] act,
                                                 logic [ffa_pkg::PID_FLD_W-1:0] pid,
                                                 logic [ffa_pkg::SIZE_W-1:0] size);
        t_alloc_resp r;
        int run;
        r = '0;
        case (act)
            ffa_pkg::ACT_ALLOC: begin
                if (size != 0 && size <= unit_limit && size <= UNITS) begin
                    run = 0;
                    for (int i = 0; i < UNITS; i++) begin
                        if (owner_tag[i][PIDB]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == size) begin
                                for (int j = i + 1 - size; j <= i; j++)
                                    owner_tag[j] = {1'b1, pid};
                                r.ok = 1'b1;
                                r.start_address = ffa_pkg::ADDR_W'(i + 1 - size);
                                break;
                            end
                        end
                    end
                end
            end
            ffa_pkg::ACT_FREE: begin
                for (int i = 0; i < UNITS; i++) begin
                    if (owner_tag[i] == {1'b1, pid}) begin
                        owner_tag[i] = '0;
                        r.ok = 1'b1;
                    end
                end
            end
            ffa_pkg::ACT_MEASURE: begin
                r.ok = 1'b1;
                r.fragment_units = ffa_pkg::FRAG_W'(free_run_total());
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string field, int expd, int got);
        $display("ERROR: %s expected %0d got %0d at %0t", field, expd, got, $realtime);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = resp_fifo.size();

    always @(posedge i_clk) begin
        t_alloc_resp e;
        t_alloc_resp pred;
        if (!i_rst_n) begin
            for (int i = 0; i < UNITS; i++) owner_tag[i] = '0;
            unit_limit = ffa_pkg::LIMIT_RESET;
            resp_fifo.delete();
        end else begin
            if (i_cfg_we) unit_limit = i_cfg_wdata;
            if (i_req.valid && i_req.ready) begin
                pred = predict_resp(i_req.action, i_req.process_id, i_req.request_size);
                resp_fifo = {resp_fifo, pred};
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (resp_fifo.size() == 0) begin
                    report("unexpected response", 0, 1);
                end else begin
                    e = resp_fifo.pop_front();
                    if (i_rsp.ok !== e.ok) report("ok", e.ok, i_rsp.ok);
                    if (i_rsp.start_address !== e.start_address)
                        report("start_address", e.start_address, i_rsp.start_address);
                    if (i_rsp.fragment_units !== e.fragment_units)
                        report("fragment_units", e.fragment_units, i_rsp.fragment_units);
                end
            end
        end
    end

endmodule

@@ verif/tb_first_fit_unit_allocator_core.sv @@
// Testbench top: drives allocator requests, config writes and idling; gives the verdict.
module tb_first_fit_unit_allocator_core;

    // Worst case per item is two ring passes plus handshakes; allow plenty of slack.
    localparam int CYCLE_LIMIT = 8_000_000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [ffa_pkg::LIMIT_W-1:0] i_cfg_wdata;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_request;
    bit hold_done;
    int hold_left;

    first_fit_unit_allocator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ffa_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: the run never outlives the cycle limit.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Response side: random back-pressure, plus one long hold-off on request.
    initial begin
        hold_done = 1'b0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done && hold_left == 0) begin
                hold_left = 3000;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // One request transfer; valid stays high between back-to-back transfers.
    task automatic send_req(logic [ffa_pkg::ACT_W-1:0] act,
                            logic [ffa_pkg::PID_FLD_W-1:0] pid,
                            logic [ffa_pkg::SIZE_W-1:0] size);
        if ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.process_id   <= pid;
        req_ch.request_size <= size;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Drain responses, let the block settle, then write the limit.
    task automatic write_limit(logic [ffa_pkg::LIMIT_W-1:0] value);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly small allocations and frees over a few owners so the map churns.
    task automatic random_req(logic [ffa_pkg::LIMIT_W-1:0] limit);
        int pick;
        logic [ffa_pkg::SIZE_W-1:0] size;
        logic [ffa_pkg::PID_FLD_W-1:0] pid;
        pick = $urandom_range(99);
        pid = ($urandom_range(9) == 0) ? ffa_pkg::PID_FLD_W'($urandom)
                                       : ffa_pkg::PID_FLD_W'($urandom_range(15));
        if (pick < 4)        size = ffa_pkg::SIZE_W'($urandom);
        else if (pick < 7)   size = '0;
        else if (pick < 12)  size = (limit == 0) ? ffa_pkg::SIZE_W'(1)
                                                 : limit - ffa_pkg::SIZE_W'($urandom_range(1));
        else                 size = ffa_pkg::SIZE_W'($urandom_range(1, 40));
        pick = $urandom_range(99);
        if (pick < 52)       send_req(ffa_pkg::ACT_ALLOC, pid, size);
        else if (pick < 77)  send_req(ffa_pkg::ACT_FREE, pid, ffa_pkg::SIZE_W'($urandom));
        else if (pick < 96)  send_req(ffa_pkg::ACT_MEASURE, pid, ffa_pkg::SIZE_W'($urandom));
        else                 send_req(ffa_pkg::ACT_UNUSED, pid, ffa_pkg::SIZE_W'($urandom));
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.action       <= ffa_pkg::ACT_ALLOC;
        req_ch.process_id   <= '0;
        req_ch.request_size <= '0;
        hold_request = 1'b0;
        tx_idle_pct  = 29;
        rx_idle_pct  = 78;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero size, oversize, full memory, unused action, id aliasing.
        send_req(ffa_pkg::ACT_ALLOC, 8'd1, 11'd0);
        send_req(ffa_pkg::ACT_ALLOC, 8'd1, 11'd1025);
        send_req(ffa_pkg::ACT_ALLOC, 8'd1, 11'd2047);
        send_req(ffa_pkg::ACT_MEASURE, 8'd0, 11'd0);
        send_req(ffa_pkg::ACT_ALLOC, 8'd255, 11'd1024);
        send_req(ffa_pkg::ACT_ALLOC, 8'd2, 11'd1);
        send_req(ffa_pkg::ACT_MEASURE, 8'd255, 11'd2047);
        send_req(ffa_pkg::ACT_FREE, 8'd3, 11'd0);
        send_req(ffa_pkg::ACT_FREE, 8'd255, 11'd0);
        send_req(ffa_pkg::ACT_UNUSED, 8'd255, 11'd2047);
        send_req(ffa_pkg::ACT_ALLOC, 8'd0, 11'd1);
        send_req(ffa_pkg::ACT_ALLOC, 8'd170, 11'd3);
        send_req(ffa_pkg::ACT_ALLOC, 8'd85, 11'd5);
        send_req(ffa_pkg::ACT_ALLOC, 8'd0, 11'd2);
        send_req(ffa_pkg::ACT_FREE, 8'd170, 11'd0);
        send_req(ffa_pkg::ACT_MEASURE, 8'd0, 11'd0);
        send_req(ffa_pkg::ACT_ALLOC, 8'd7, 11'd2);
        send_req(ffa_pkg::ACT_ALLOC, 8'd7, 11'd1018);
        send_req(ffa_pkg::ACT_MEASURE, 8'd0, 11'd0);
        send_req(ffa_pkg::ACT_FREE, 8'd0, 11'd0);
        send_req(ffa_pkg::ACT_FREE, 8'd85, 11'd0);
        send_req(ffa_pkg::ACT_MEASURE, 8'd0, 11'd0);

        // Long receiver hold-off while requests keep coming.
        write_limit(11'd64);
        hold_request = 1'b1;
        repeat (200) random_req(11'd64);
        hold_request = 1'b0;

        // Sender pause until every response is back.
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        tx_idle_pct = 78;
        rx_idle_pct = 29;
        write_limit(11'd1);
        repeat (30) random_req(11'd1);
        write_limit(11'd0);
        repeat (20) random_req(11'd0);
        write_limit(11'd2047);
        repeat (130) random_req(11'd2047);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_limit(11'd1024);
        repeat (200) random_req(11'd1024);

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
